FILE: rtl/core/chip8_instruction_executor_macros.svh
// Assertion macros shared by the executor modules.
// Each check is sampled on i_clk and ignored while i_rst_n is low.
`ifndef CHIP8_INSTRUCTION_EXECUTOR_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTOR_MACROS_SVH

`ifndef ASSERT_OFF
`define C8IE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define C8IE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define C8IE_ASSERT_IMP(lbl, ante, cons)
`define C8IE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/core/c8ie_pkg.sv
`timescale 1ns / 1ps

package c8ie_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int STACK_DEPTH = 16;
    localparam int MEM_AW      = $clog2(MEM_BYTES);
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = 12;
    localparam int FONT_BYTES  = 80;

    localparam logic [ADDR_W-1:0] START_RESET = 12'h200;
    localparam logic [15:0]       OP_RET      = 16'h00EE;

    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_STEP   = 2'd1;
    localparam logic [1:0] KIND_RD_MEM = 2'd2;
    localparam logic [1:0] KIND_RD_REG = 2'd3;

    localparam logic [3:0] OPC_SYS   = 4'h0;
    localparam logic [3:0] OPC_JP    = 4'h1;
    localparam logic [3:0] OPC_CALL  = 4'h2;
    localparam logic [3:0] OPC_SE_K  = 4'h3;
    localparam logic [3:0] OPC_SNE_K = 4'h4;
    localparam logic [3:0] OPC_SE_V  = 4'h5;
    localparam logic [3:0] OPC_LD_K  = 4'h6;
    localparam logic [3:0] OPC_ADD_K = 4'h7;
    localparam logic [3:0] OPC_ALU   = 4'h8;
    localparam logic [3:0] OPC_SNE_V = 4'h9;
    localparam logic [3:0] OPC_LD_I  = 4'hA;
    localparam logic [3:0] OPC_JP_V0 = 4'hB;
    localparam logic [3:0] OPC_RND   = 4'hC;
    localparam logic [3:0] OPC_MISC  = 4'hF;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [7:0] MISC_KEY   = 8'h0A;
    localparam logic [7:0] MISC_ADDI  = 8'h1E;
    localparam logic [7:0] MISC_FONT  = 8'h29;
    localparam logic [7:0] MISC_BCD   = 8'h33;
    localparam logic [7:0] MISC_STORE = 8'h55;
    localparam logic [7:0] MISC_LOAD  = 8'h65;

    localparam logic [3:0] VF_IDX = 4'hF;

    localparam logic [7:0] FONT [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [1:0] {
        CLS_SIMPLE,
        CLS_BCD,
        CLS_STORE,
        CLS_LOAD
    } t_op_class;

    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_CLEAR,
        UOP_ACCEPT,
        UOP_LOAD,
        UOP_RD_MEM,
        UOP_RD_REG,
        UOP_FETCH_HI,
        UOP_FETCH_LO,
        UOP_READ_X,
        UOP_READ_Y,
        UOP_EXEC,
        UOP_WR_VF,
        UOP_BCD,
        UOP_ST_RD,
        UOP_ST_WR,
        UOP_LD_RD,
        UOP_LD_WR,
        UOP_DONE
    } t_uop;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_RD_MEM,
        ST_RD_REG,
        ST_FETCH_HI,
        ST_FETCH_LO,
        ST_READ_X,
        ST_READ_Y,
        ST_EXEC,
        ST_WR_VF,
        ST_BCD,
        ST_ST_RD,
        ST_ST_WR,
        ST_LD_RD,
        ST_LD_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] kind;
        t_op_class  op_class;
        logic       need_vf;
        logic       cnt_eq_x;
        logic       cnt_eq_two;
        logic       clear_last;
        logic       out_free;
    } t_dp_status;

    function automatic t_op_class op_class_of(input logic [15:0] op);
        t_op_class cls;
        cls = CLS_SIMPLE;
        if (op[15:12] == OPC_MISC) begin
            if (op[7:0] == MISC_BCD) begin
                cls = CLS_BCD;
            end else if (op[7:0] == MISC_STORE) begin
                cls = CLS_STORE;
            end else if (op[7:0] == MISC_LOAD) begin
                cls = CLS_LOAD;
            end
        end
        return cls;
    endfunction

    // Decimal digit of an 8-bit value: 0 hundreds, 1 tens, 2 ones.
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [1:0]  hund;
        logic [7:0]  rem8;
        logic [6:0]  rem;
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        logic [7:0]  dig;
        if (v >= 8'd200) begin
            hund = 2'd2;
            rem8 = v - 8'd200;
        end else if (v >= 8'd100) begin
            hund = 2'd1;
            rem8 = v - 8'd100;
        end else begin
            hund = 2'd0;
            rem8 = v;
        end
        rem  = rem8[6:0];
        prod = 15'({8'd0, rem} * 15'd205);
        tens = prod[14:11];
        ones = rem - 7'({3'd0, tens} * 7'd10);
        if (sel == 2'd0) begin
            dig = {6'd0, hund};
        end else if (sel == 2'd1) begin
            dig = {4'd0, tens};
        end else begin
            dig = {1'b0, ones};
        end
        return dig;
    endfunction

endpackage

FILE: rtl/core/chip8_instruction_executor.sv
`timescale 1ns / 1ps
// CHIP-8 instruction executor.
// The input channel (i_in_valid / o_in_stall) carries one item per transfer:
// a program byte load, one instruction step, a memory byte read, or a V
// register read. Every item gives exactly one result on the output channel
// (o_out_valid / i_out_stall) with the read byte and the machine status.
// A load or read goes from its working state to the done state. A step fetches
// both opcode bytes, reads VX and VY, executes, then writes VF or the BCD
// digits or stores or loads the register block as the opcode needs, and ends
// in the done state. Memory and register file each have one read and one
// write port; one item is worked on at a time, the next taken in idle after done.
// The start address register is written through i_cfg_we / i_cfg_data; the user
// must write it only while the block is idle; the block does not enforce this.
// After reset the block sweeps the 4096-byte memory, one byte a cycle, to put
// the font sprites in place and zero the rest, and clears the V registers;
// o_in_stall stays high until the sweep ends.
// A result held by i_out_stall stays on the output register; the block
// accepts the next item but holds its result until the output transfer.

module chip8_instruction_executor
    import c8ie_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_kind,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [7:0]        i_load_data,
    input  logic [3:0]        i_reg_index,
    input  logic [7:0]        i_random_byte,
    input  logic [3:0]        i_key_value,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_read_data,
    output logic [ADDR_W-1:0] o_prog_counter,
    output logic [ADDR_W-1:0] o_index_reg,
    output logic [4:0]        o_stack_level,
    output logic              o_terminated,
    output logic              o_stack_fault
);

    t_uop       uop;
    t_dp_status status;

    c8ie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_uop      (uop)
    );

    c8ie_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_uop          (uop),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_address      (i_address),
        .i_load_data    (i_load_data),
        .i_reg_index    (i_reg_index),
        .i_random_byte  (i_random_byte),
        .i_key_value    (i_key_value),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_read_data    (o_read_data),
        .o_prog_counter (o_prog_counter),
        .o_index_reg    (o_index_reg),
        .o_stack_level  (o_stack_level),
        .o_terminated   (o_terminated),
        .o_stack_fault  (o_stack_fault)
    );

endmodule

FILE: rtl/core/c8ie_ram.sv
`timescale 1ns / 1ps

module c8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/c8ie_ctrl.sv
`timescale 1ns / 1ps
`include "chip8_instruction_executor_macros.svh"

module c8ie_ctrl
    import c8ie_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_uop       o_uop
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_uop      = UOP_NONE;
        o_in_stall = (r_state != ST_IDLE);
        unique case (r_state)
            ST_CLEAR: begin
                o_uop = UOP_CLEAR;
                if (i_status.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_uop = UOP_ACCEPT;
                    n_state = ST_DONE;
                end
            end
            ST_LOAD: begin
                o_uop = UOP_LOAD;
                n_state = ST_DONE;
            end
            ST_RD_MEM: begin
                o_uop = UOP_RD_MEM;
                n_state = ST_DONE;
            end
            ST_RD_REG: begin
                o_uop = UOP_RD_REG;
                n_state = ST_DONE;
            end
            ST_FETCH_HI: begin
                o_uop = UOP_FETCH_HI;
                n_state = ST_FETCH_LO;
            end
            ST_FETCH_LO: begin
                o_uop = UOP_FETCH_LO;
                n_state = ST_READ_X;
            end
            ST_READ_X: begin
                o_uop = UOP_READ_X;
                n_state = ST_READ_Y;
            end
            ST_READ_Y: begin
                o_uop = UOP_READ_Y;
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                o_uop = UOP_EXEC;
                unique case (i_status.op_class)
                    CLS_BCD:   n_state = ST_BCD;
                    CLS_STORE: n_state = ST_ST_RD;
                    CLS_LOAD:  n_state = ST_LD_RD;
                    default:   n_state = i_status.need_vf ? ST_WR_VF : ST_DONE;
                endcase
            end
            ST_WR_VF: begin
                o_uop = UOP_WR_VF;
                n_state = ST_DONE;
            end
            ST_BCD: begin
                o_uop = UOP_BCD;
                if (i_status.cnt_eq_two) begin
                    n_state = ST_DONE;
                end
            end
            ST_ST_RD: begin
                o_uop = UOP_ST_RD;
                n_state = ST_ST_WR;
            end
            ST_ST_WR: begin
                o_uop = UOP_ST_WR;
                n_state = i_status.cnt_eq_x ? ST_DONE : ST_ST_RD;
            end
            ST_LD_RD: begin
                o_uop = UOP_LD_RD;
                n_state = ST_LD_WR;
            end
            ST_LD_WR: begin
                o_uop = UOP_LD_WR;
                n_state = i_status.cnt_eq_x ? ST_DONE : ST_LD_RD;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_uop = UOP_DONE;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        // The accepted kind picks the first working state.
        if (r_state == ST_IDLE && i_in_valid) begin
            unique case (i_status.kind)
                KIND_LOAD:   n_state = ST_LOAD;
                KIND_STEP:   n_state = ST_FETCH_HI;
                KIND_RD_MEM: n_state = ST_RD_MEM;
                default:     n_state = ST_RD_REG;
            endcase
        end
    end

    `C8IE_ASSERT_NXT(a_clear_holds, r_state == ST_CLEAR && !i_status.clear_last,
                     r_state == ST_CLEAR)
    `C8IE_ASSERT_NXT(a_exec_follows_read, r_state == ST_READ_Y, r_state == ST_EXEC)
    `C8IE_ASSERT_NXT(a_done_to_idle, r_state == ST_DONE && i_status.out_free,
                     r_state == ST_IDLE)

endmodule

FILE: rtl/core/c8ie_datapath.sv
`timescale 1ns / 1ps
`include "chip8_instruction_executor_macros.svh"

module c8ie_datapath
    import c8ie_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_uop              i_uop,
    output t_dp_status        o_status,
    input  logic              i_cfg_we,
    input  logic [ADDR_W-1:0] i_cfg_data,
    input  logic [1:0]        i_kind,
    input  logic [ADDR_W-1:0] i_address,
    input  logic [7:0]        i_load_data,
    input  logic [3:0]        i_reg_index,
    input  logic [7:0]        i_random_byte,
    input  logic [3:0]        i_key_value,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [7:0]        o_read_data,
    output logic [ADDR_W-1:0] o_prog_counter,
    output logic [ADDR_W-1:0] o_index_reg,
    output logic [4:0]        o_stack_level,
    output logic              o_terminated,
    output logic              o_stack_fault
);

    logic [ADDR_W-1:0] r_start, n_start;
    logic [ADDR_W-1:0] r_pc, n_pc;
    logic [ADDR_W-1:0] r_idx, n_idx;
    logic [SP_W-1:0]   r_sp, n_sp;
    logic              r_term, n_term;
    logic              r_fault, n_fault;
    logic [MEM_AW-1:0] r_clr, n_clr;
    logic              r_out_valid, n_out_valid;

    logic [1:0]        r_kind, n_kind;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [7:0]        r_ldata, n_ldata;
    logic [3:0]        r_regi, n_regi;
    logic [7:0]        r_rnd, n_rnd;
    logic [3:0]        r_key, n_key;
    logic [7:0]        r_op_hi, n_op_hi;
    logic [15:0]       r_op, n_op;
    logic [7:0]        r_vx, n_vx;
    logic              r_flag, n_flag;
    logic [3:0]        r_cnt, n_cnt;

    logic [7:0]        r_out_rd, n_out_rd;
    logic [ADDR_W-1:0] r_out_pc, n_out_pc;
    logic [ADDR_W-1:0] r_out_idx, n_out_idx;
    logic [SP_W-1:0]   r_out_sp, n_out_sp;
    logic              r_out_term, n_out_term;
    logic              r_out_fault, n_out_fault;

    logic                mem_we, mem_re;
    logic [MEM_AW-1:0]   mem_waddr, mem_raddr;
    logic [7:0]          mem_wdata, mem_rdata;
    logic                vr_we, vr_re;
    logic [3:0]          vr_waddr, vr_raddr;
    logic [7:0]          vr_wdata, vr_rdata;
    logic                stk_we, stk_re;
    logic [STACK_AW-1:0] stk_waddr, stk_raddr;
    logic [ADDR_W-1:0]   stk_wdata, stk_rdata;

    logic [3:0]        op_x;
    logic [ADDR_W-1:0] idx_cnt;
    logic [ADDR_W-1:0] pc_plus2;
    logic [8:0]        sum9;
    logic [SP_W-1:0]   sp_dec;

    c8ie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    c8ie_ram #(.WIDTH(8), .DEPTH(16)) u_vregs (
        .i_clk   (i_clk),
        .i_we    (vr_we),
        .i_waddr (vr_waddr),
        .i_wdata (vr_wdata),
        .i_re    (vr_re),
        .i_raddr (vr_raddr),
        .o_rdata (vr_rdata)
    );

    c8ie_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    assign op_x     = r_op[11:8];
    assign idx_cnt  = r_idx + {{(ADDR_W-4){1'b0}}, r_cnt};
    assign pc_plus2 = r_pc + ADDR_W'(2);
    assign sum9     = {1'b0, r_vx} + {1'b0, vr_rdata};
    assign sp_dec   = r_sp - SP_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= START_RESET;
            r_pc        <= START_RESET;
            r_idx       <= '0;
            r_sp        <= '0;
            r_term      <= 1'b0;
            r_fault     <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_start     <= n_start;
            r_pc        <= n_pc;
            r_idx       <= n_idx;
            r_sp        <= n_sp;
            r_term      <= n_term;
            r_fault     <= n_fault;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_addr      <= n_addr;
        r_ldata     <= n_ldata;
        r_regi      <= n_regi;
        r_rnd       <= n_rnd;
        r_key       <= n_key;
        r_op_hi     <= n_op_hi;
        r_op        <= n_op;
        r_vx        <= n_vx;
        r_flag      <= n_flag;
        r_cnt       <= n_cnt;
        r_out_rd    <= n_out_rd;
        r_out_pc    <= n_out_pc;
        r_out_idx   <= n_out_idx;
        r_out_sp    <= n_out_sp;
        r_out_term  <= n_out_term;
        r_out_fault <= n_out_fault;
    end

    always_comb begin
        n_start     = i_cfg_we ? i_cfg_data : r_start;
        n_pc        = r_pc;
        n_idx       = r_idx;
        n_sp        = r_sp;
        n_term      = r_term;
        n_fault     = r_fault;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && i_out_stall;
        n_kind      = r_kind;
        n_addr      = r_addr;
        n_ldata     = r_ldata;
        n_regi      = r_regi;
        n_rnd       = r_rnd;
        n_key       = r_key;
        n_op_hi     = r_op_hi;
        n_op        = r_op;
        n_vx        = r_vx;
        n_flag      = r_flag;
        n_cnt       = r_cnt;
        n_out_rd    = r_out_rd;
        n_out_pc    = r_out_pc;
        n_out_idx   = r_out_idx;
        n_out_sp    = r_out_sp;
        n_out_term  = r_out_term;
        n_out_fault = r_out_fault;

        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;
        vr_we     = 1'b0;
        vr_waddr  = '0;
        vr_wdata  = '0;
        vr_re     = 1'b0;
        vr_raddr  = '0;
        stk_we    = 1'b0;
        stk_waddr = r_sp[STACK_AW-1:0];
        stk_wdata = r_pc;
        stk_re    = 1'b0;
        stk_raddr = sp_dec[STACK_AW-1:0];

        unique case (i_uop)
            UOP_NONE: begin
            end
            UOP_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = (r_clr < MEM_AW'(FONT_BYTES)) ? FONT[r_clr[6:0]] : 8'h00;
                vr_we     = 1'b1;
                vr_waddr  = r_clr[3:0];
                n_clr     = r_clr + MEM_AW'(1);
            end
            UOP_ACCEPT: begin
                n_kind  = i_kind;
                n_addr  = i_address;
                n_ldata = i_load_data;
                n_regi  = i_reg_index;
                n_rnd   = i_random_byte;
                n_key   = i_key_value;
            end
            UOP_LOAD: begin
                mem_we    = 1'b1;
                mem_waddr = MEM_AW'(r_start + r_addr);
                mem_wdata = r_ldata;
            end
            UOP_RD_MEM: begin
                mem_re    = 1'b1;
                mem_raddr = MEM_AW'(r_addr);
            end
            UOP_RD_REG: begin
                vr_re    = 1'b1;
                vr_raddr = r_regi;
            end
            UOP_FETCH_HI: begin
                mem_re    = 1'b1;
                mem_raddr = MEM_AW'(r_pc);
            end
            UOP_FETCH_LO: begin
                n_op_hi   = mem_rdata;
                mem_re    = 1'b1;
                mem_raddr = MEM_AW'(r_pc + ADDR_W'(1));
            end
            UOP_READ_X: begin
                n_op     = {r_op_hi, mem_rdata};
                n_pc     = pc_plus2;
                vr_re    = 1'b1;
                vr_raddr = r_op_hi[3:0];
            end
            UOP_READ_Y: begin
                // BNNN needs V0 in the slot where VY normally goes.
                n_vx     = vr_rdata;
                vr_re    = 1'b1;
                vr_raddr = (r_op[15:12] == OPC_JP_V0) ? 4'h0 : r_op[7:4];
                stk_re   = 1'b1;
            end
            UOP_EXEC: begin
                n_cnt    = '0;
                vr_waddr = op_x;
                unique case (r_op[15:12])
                    OPC_SYS: begin
                        if (r_op == OP_RET) begin
                            if (r_sp == '0) begin
                                n_term = 1'b1;
                            end else begin
                                n_sp = sp_dec;
                                n_pc = stk_rdata;
                            end
                        end
                    end
                    OPC_JP: n_pc = r_op[11:0];
                    OPC_CALL: begin
                        if (r_sp >= SP_W'(STACK_DEPTH)) begin
                            n_fault = 1'b1;
                        end else begin
                            stk_we = 1'b1;
                            n_sp   = r_sp + SP_W'(1);
                        end
                        n_pc = r_op[11:0];
                    end
                    OPC_SE_K:  if (r_vx == r_op[7:0]) n_pc = pc_plus2;
                    OPC_SNE_K: if (r_vx != r_op[7:0]) n_pc = pc_plus2;
                    OPC_SE_V:  if (r_vx == vr_rdata) n_pc = pc_plus2;
                    OPC_SNE_V: if (r_vx != vr_rdata) n_pc = pc_plus2;
                    OPC_LD_K: begin
                        vr_we    = 1'b1;
                        vr_wdata = r_op[7:0];
                    end
                    OPC_ADD_K: begin
                        vr_we    = 1'b1;
                        vr_wdata = r_vx + r_op[7:0];
                    end
                    OPC_ALU: begin
                        unique case (r_op[3:0])
                            ALU_MOV: begin
                                vr_we    = 1'b1;
                                vr_wdata = vr_rdata;
                            end
                            ALU_OR: begin
                                vr_we    = 1'b1;
                                vr_wdata = r_vx | vr_rdata;
                            end
                            ALU_AND: begin
                                vr_we    = 1'b1;
                                vr_wdata = r_vx & vr_rdata;
                            end
                            ALU_XOR: begin
                                vr_we    = 1'b1;
                                vr_wdata = r_vx ^ vr_rdata;
                            end
                            ALU_ADD: begin
                                vr_we    = 1'b1;
                                vr_wdata = sum9[7:0];
                                n_flag   = sum9[8];
                            end
                            ALU_SUB: begin
                                vr_we    = 1'b1;
                                vr_wdata = r_vx - vr_rdata;
                                n_flag   = (r_vx > vr_rdata);
                            end
                            ALU_SHR: begin
                                vr_we    = 1'b1;
                                vr_wdata = {1'b0, r_vx[7:1]};
                                n_flag   = r_vx[0];
                            end
                            ALU_SUBN: begin
                                vr_we    = 1'b1;
                                vr_wdata = vr_rdata - r_vx;
                                n_flag   = (vr_rdata > r_vx);
                            end
                            ALU_SHL: begin
                                vr_we    = 1'b1;
                                vr_wdata = {r_vx[6:0], 1'b0};
                                n_flag   = r_vx[7];
                            end
                            default: begin
                            end
                        endcase
                    end
                    OPC_LD_I:  n_idx = r_op[11:0];
                    OPC_JP_V0: n_pc = {4'h0, vr_rdata} + r_op[11:0];
                    OPC_RND: begin
                        vr_we    = 1'b1;
                        vr_wdata = r_rnd & r_op[7:0];
                    end
                    OPC_MISC: begin
                        if (r_op[7:0] == MISC_KEY) begin
                            vr_we    = 1'b1;
                            vr_wdata = {4'h0, r_key};
                        end else if (r_op[7:0] == MISC_ADDI) begin
                            n_idx = r_idx + {4'h0, r_vx};
                        end else if (r_op[7:0] == MISC_FONT) begin
                            n_idx = {6'd0, r_vx[3:0], 2'b00} + {8'd0, r_vx[3:0]};
                        end
                    end
                    default: begin
                    end
                endcase
            end
            UOP_WR_VF: begin
                vr_we    = 1'b1;
                vr_waddr = VF_IDX;
                vr_wdata = {7'd0, r_flag};
            end
            UOP_BCD: begin
                mem_we    = 1'b1;
                mem_waddr = MEM_AW'(idx_cnt);
                mem_wdata = bcd_digit(r_vx, r_cnt[1:0]);
                n_cnt     = r_cnt + 4'd1;
            end
            UOP_ST_RD: begin
                vr_re    = 1'b1;
                vr_raddr = r_cnt;
            end
            UOP_ST_WR: begin
                mem_we    = 1'b1;
                mem_waddr = MEM_AW'(idx_cnt);
                mem_wdata = vr_rdata;
                n_cnt     = r_cnt + 4'd1;
            end
            UOP_LD_RD: begin
                mem_re    = 1'b1;
                mem_raddr = MEM_AW'(idx_cnt);
            end
            UOP_LD_WR: begin
                vr_we    = 1'b1;
                vr_waddr = r_cnt;
                vr_wdata = mem_rdata;
                n_cnt    = r_cnt + 4'd1;
            end
            UOP_DONE: begin
                n_out_valid = 1'b1;
                unique case (r_kind)
                    KIND_RD_MEM: n_out_rd = mem_rdata;
                    KIND_RD_REG: n_out_rd = vr_rdata;
                    default:     n_out_rd = 8'h00;
                endcase
                n_out_pc    = r_pc;
                n_out_idx   = r_idx;
                n_out_sp    = r_sp;
                n_out_term  = r_term;
                n_out_fault = r_fault;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_status.kind       = i_kind;
        o_status.op_class   = op_class_of(r_op);
        o_status.need_vf    = (r_op[15:12] == OPC_ALU) && (op_x != VF_IDX) &&
                              (r_op[3:0] == ALU_ADD || r_op[3:0] == ALU_SUB ||
                               r_op[3:0] == ALU_SHR || r_op[3:0] == ALU_SUBN ||
                               r_op[3:0] == ALU_SHL);
        o_status.cnt_eq_x   = (r_cnt == op_x);
        o_status.cnt_eq_two = (r_cnt == 4'd2);
        o_status.clear_last = (r_clr == {MEM_AW{1'b1}});
        o_status.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_out_rd;
    assign o_prog_counter = r_out_pc;
    assign o_index_reg    = r_out_idx;
    assign o_stack_level  = 5'(r_out_sp);
    assign o_terminated   = r_out_term;
    assign o_stack_fault  = r_out_fault;

    `C8IE_ASSERT_IMP(a_sp_in_range, 1'b1, r_sp <= SP_W'(STACK_DEPTH))
    `C8IE_ASSERT_NXT(a_term_sticky, r_term, r_term)

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb
    import c8ie_pkg::*;
;

    typedef struct packed {
        logic [1:0]  kind;
        logic [11:0] address;
        logic [7:0]  load_data;
        logic [3:0]  reg_index;
        logic [7:0]  random_byte;
        logic [3:0]  key_value;
    } t_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [11:0] prog_counter;
        logic [11:0] index_reg;
        logic [4:0]  stack_level;
        logic        terminated;
        logic        stack_fault;
    } t_status;

    localparam int WATCHDOG_LIMIT = 20000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [ADDR_W-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_kind = '0;
    logic [ADDR_W-1:0] i_address = '0;
    logic [7:0]        i_load_data = '0;
    logic [3:0]        i_reg_index = '0;
    logic [7:0]        i_random_byte = '0;
    logic [3:0]        i_key_value = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [7:0]        o_read_data;
    logic [ADDR_W-1:0] o_prog_counter;
    logic [ADDR_W-1:0] o_index_reg;
    logic [4:0]        o_stack_level;
    logic              o_terminated;
    logic              o_stack_fault;

    chip8_instruction_executor uut (.*);

    always #6 i_clk = ~i_clk;

    // Shadow machine state.
    logic [7:0]  mem_img [MEM_BYTES];
    logic [7:0]  vreg_img [16];
    logic [11:0] call_stack [STACK_DEPTH];
    logic [11:0] pc_img;
    logic [11:0] i_img;
    logic [4:0]  sp_img;
    logic        term_img;
    logic        fault_img;
    logic [11:0] base_addr;

    t_item   pending_items [$];
    t_status expected_status [$];
    int      error_count = 0;
    bit      quiet_mode = 1'b0;
    bit      hold_sender = 1'b0;
    int      idle_cycles = 0;

    logic [11:0] pc_img_plan;
    logic [11:0] base_plan;

    function automatic logic [11:0] mem_index(input logic [11:0] a);
        return 12'(a % MEM_BYTES);
    endfunction

    function automatic void reset_machine();
        for (int k = 0; k < MEM_BYTES; k++) mem_img[k] = (k < FONT_BYTES) ? FONT[k] : 8'h00;
        for (int k = 0; k < 16; k++) vreg_img[k] = 8'h00;
        for (int k = 0; k < STACK_DEPTH; k++) call_stack[k] = '0;
        base_addr = START_RESET;
        pc_img = START_RESET;
        i_img = '0;
        sp_img = '0;
        term_img = 1'b0;
        fault_img = 1'b0;
    endfunction

    function automatic void execute_opcode(input logic [15:0] op, input logic [7:0] rnd,
                                           input logic [3:0] key);
        logic [3:0]  x;
        logic [3:0]  y;
        logic [11:0] nnn;
        logic [7:0]  kk;
        logic [7:0]  vx;
        logic [7:0]  vy;
        x = op[11:8];
        y = op[7:4];
        nnn = op[11:0];
        kk = op[7:0];
        vx = vreg_img[x];
        vy = vreg_img[y];
        case (op[15:12])
            OPC_SYS: begin
                if (op == OP_RET) begin
                    if (sp_img == 0) begin
                        term_img = 1'b1;
                    end else begin
                        sp_img--;
                        pc_img = call_stack[sp_img];
                    end
                end
            end
            OPC_JP: pc_img = nnn;
            OPC_CALL: begin
                if (sp_img >= STACK_DEPTH) begin
                    fault_img = 1'b1;
                end else begin
                    call_stack[sp_img] = pc_img;
                    sp_img++;
                end
                pc_img = nnn;
            end
            OPC_SE_K: if (vx == kk) pc_img = pc_img + 12'd2;
            OPC_SNE_K: if (vx != kk) pc_img = pc_img + 12'd2;
            OPC_SE_V: if (vx == vy) pc_img = pc_img + 12'd2;
            OPC_LD_K: vreg_img[x] = kk;
            OPC_ADD_K: vreg_img[x] = vx + kk;
            OPC_ALU: begin
                case (op[3:0])
                    ALU_MOV: vreg_img[x] = vy;
                    ALU_OR: vreg_img[x] = vx | vy;
                    ALU_AND: vreg_img[x] = vx & vy;
                    ALU_XOR: vreg_img[x] = vx ^ vy;
                    ALU_ADD: begin
                        vreg_img[VF_IDX] = ({1'b0, vx} + vy > 9'd255) ? 8'd1 : 8'd0;
                        vreg_img[x] = vx + vy;
                    end
                    ALU_SUB: begin
                        vreg_img[VF_IDX] = (vx > vy) ? 8'd1 : 8'd0;
                        vreg_img[x] = vx - vy;
                    end
                    ALU_SHR: begin
                        vreg_img[VF_IDX] = {7'd0, vx[0]};
                        vreg_img[x] = vx >> 1;
                    end
                    ALU_SUBN: begin
                        vreg_img[VF_IDX] = (vy > vx) ? 8'd1 : 8'd0;
                        vreg_img[x] = vy - vx;
                    end
                    ALU_SHL: begin
                        vreg_img[VF_IDX] = {7'd0, vx[7]};
                        vreg_img[x] = vx << 1;
                    end
                    default: ;
                endcase
            end
            OPC_SNE_V: if (vx != vy) pc_img = pc_img + 12'd2;
            OPC_LD_I: i_img = nnn;
            OPC_JP_V0: pc_img = {4'd0, vreg_img[0]} + nnn;
            OPC_RND: vreg_img[x] = rnd & kk;
            OPC_MISC: begin
                case (kk)
                    MISC_KEY: vreg_img[x] = {4'd0, key};
                    MISC_ADDI: i_img = i_img + {4'd0, vx};
                    MISC_FONT: i_img = 12'd5 * {8'd0, vx[3:0]};
                    MISC_BCD: begin
                        mem_img[mem_index(i_img)] = 8'(vx / 100);
                        mem_img[mem_index(i_img + 12'd1)] = 8'((vx / 10) % 10);
                        mem_img[mem_index(i_img + 12'd2)] = 8'(vx % 10);
                    end
                    MISC_STORE: begin
                        for (int k = 0; k <= x; k++)
                            mem_img[mem_index(12'(i_img + k))] = vreg_img[k];
                    end
                    MISC_LOAD: begin
                        for (int k = 0; k <= x; k++)
                            vreg_img[k] = mem_img[mem_index(12'(i_img + k))];
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endfunction

    function automatic t_status predict_status(input t_item it);
        t_status st;
        logic [15:0] op;
        st.read_data = 8'h00;
        case (it.kind)
            KIND_LOAD: mem_img[mem_index(base_addr + it.address)] = it.load_data;
            KIND_STEP: begin
                op = {mem_img[mem_index(pc_img)], mem_img[mem_index(pc_img + 12'd1)]};
                pc_img = pc_img + 12'd2;
                execute_opcode(op, it.random_byte, it.key_value);
            end
            KIND_RD_MEM: st.read_data = mem_img[mem_index(it.address)];
            default: st.read_data = vreg_img[it.reg_index];
        endcase
        st.prog_counter = pc_img;
        st.index_reg = i_img;
        st.stack_level = sp_img;
        st.terminated = term_img;
        st.stack_fault = fault_img;
        return st;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Sender: one item per transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || !o_in_stall) begin
                if (pending_items.size() > 0 && !hold_sender &&
                    (quiet_mode || $urandom_range(99) >= 28)) begin
                    t_item it;
                    it = pending_items.pop_front();
                    expected_status.push_back(predict_status(it));
                    i_in_valid <= 1'b1;
                    i_kind <= it.kind;
                    i_address <= it.address;
                    i_load_data <= it.load_data;
                    i_reg_index <= it.reg_index;
                    i_random_byte <= it.random_byte;
                    i_key_value <= it.key_value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= quiet_mode ? 1'b0 : ($urandom_range(99) < 28);
        end
    end

    // Result checker.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_out_valid && !i_out_stall) begin
                if (expected_status.size() == 0) begin
                    report_mismatch("unexpected transfer", 0, 0);
                end else begin
                    t_status e;
                    e = expected_status.pop_front();
                    if (o_read_data !== e.read_data)
                        report_mismatch("read_data", 32'(o_read_data), 32'(e.read_data));
                    if (o_prog_counter !== e.prog_counter)
                        report_mismatch("prog_counter", 32'(o_prog_counter),
                                        32'(e.prog_counter));
                    if (o_index_reg !== e.index_reg)
                        report_mismatch("index_reg", 32'(o_index_reg), 32'(e.index_reg));
                    if (o_stack_level !== e.stack_level)
                        report_mismatch("stack_level", 32'(o_stack_level),
                                        32'(e.stack_level));
                    if (o_terminated !== e.terminated)
                        report_mismatch("terminated", 32'(o_terminated), 32'(e.terminated));
                    if (o_stack_fault !== e.stack_fault)
                        report_mismatch("stack_fault", 32'(o_stack_fault),
                                        32'(e.stack_fault));
                end
            end
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    function automatic t_item make_item(input logic [1:0] kind, input logic [11:0] address,
                                        input logic [7:0] data);
        t_item it;
        it.kind = kind;
        it.address = address;
        it.load_data = data;
        it.reg_index = 4'($urandom_range(15));
        it.random_byte = 8'($urandom_range(255));
        it.key_value = 4'($urandom_range(15));
        return it;
    endfunction

    function automatic logic [15:0] random_opcode();
        logic [15:0] op;
        int pick;
        op = 16'($urandom_range(16'hFFFF));
        pick = $urandom_range(99);
        if (pick < 10) begin
            op = 16'h6000 | (op & 16'h0FFF);
        end else if (pick < 30) begin
            op[15:12] = OPC_ALU;
        end else if (pick < 45) begin
            op[15:12] = OPC_MISC;
            case ($urandom_range(5))
                0: op[7:0] = MISC_KEY;
                1: op[7:0] = MISC_ADDI;
                2: op[7:0] = MISC_FONT;
                3: op[7:0] = MISC_BCD;
                4: op[7:0] = MISC_STORE;
                default: op[7:0] = MISC_LOAD;
            endcase
        end else if (pick < 50) begin
            op = OP_RET;
        end else if (pick < 55) begin
            op[15:12] = OPC_CALL;
        end
        return op;
    endfunction

    task automatic add_program(input int len);
        logic [15:0] op;
        for (int k = 0; k < len; k++) begin
            op = random_opcode();
            pending_items.push_back(make_item(KIND_LOAD,
                                              12'(pc_img_plan + 2 * k - base_plan), op[15:8]));
            pending_items.push_back(make_item(KIND_LOAD,
                                              12'(pc_img_plan + 2 * k - base_plan + 1),
                                              op[7:0]));
        end
    endtask

    task automatic wait_drained();
        hold_sender = 1'b0;
        while (pending_items.size() > 0 || expected_status.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    task automatic write_base(input logic [11:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        base_addr = value;
    endtask

    task automatic add_reads();
        pending_items.push_back(make_item(KIND_RD_REG, 12'($urandom_range(4095)),
                                          8'($urandom_range(255))));
        pending_items.push_back(make_item(KIND_RD_MEM, 12'($urandom_range(4095)),
                                          8'($urandom_range(255))));
    endtask

    initial begin
        logic [15:0] directed_ops [$];
        logic [11:0] bases [4];
        t_item it;
        reset_machine();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed program at the reset base.
        directed_ops = '{16'h60FF, 16'h61FF, 16'h8014, 16'h8F15, 16'h8F16, 16'h8F1E,
                         16'h8107, 16'hA123, 16'hF01E, 16'hF029, 16'hFF33, 16'hC1AA,
                         16'hF20A, 16'h3200, 16'h2FFE, 16'h00EE, 16'h00EE, 16'hFF55};
        base_plan = START_RESET;
        foreach (directed_ops[k]) begin
            pending_items.push_back(make_item(KIND_LOAD, 12'(2 * k), directed_ops[k][15:8]));
            pending_items.push_back(make_item(KIND_LOAD, 12'(2 * k + 1), directed_ops[k][7:0]));
        end
        pending_items.push_back(make_item(KIND_LOAD, 12'hDFE, 8'h00));
        pending_items.push_back(make_item(KIND_LOAD, 12'hDFF, 8'hEE));
        for (int k = 0; k < 16; k++) begin
            it = make_item(KIND_STEP, 12'd0, 8'd0);
            pending_items.push_back(it);
        end
        pending_items.push_back(make_item(KIND_RD_MEM, 12'hFFF, 8'h00));
        pending_items.push_back(make_item(KIND_RD_MEM, 12'h000, 8'h00));
        for (int k = 0; k < 16; k++) begin
            it = make_item(KIND_RD_REG, 12'd0, 8'd0);
            it.reg_index = 4'(k);
            pending_items.push_back(it);
        end
        hold_sender = 1'b1;
        repeat (50) @(posedge i_clk);
        wait_drained();

        // Random phases at several base addresses, extremes included.
        bases = '{12'h000, 12'hFFF, 12'h200, 12'h7A0};
        for (int phase = 0; phase < 6; phase++) begin
            write_base(phase < 4 ? bases[phase] : 12'($urandom_range(4095)));
            quiet_mode = (phase == 2);
            pc_img_plan = pc_img;
            base_plan = base_addr;
            add_program(12);
            for (int k = 0; k < 20; k++) begin
                it = make_item(KIND_STEP, 12'($urandom_range(4095)), 8'($urandom_range(255)));
                pending_items.push_back(it);
                if ($urandom_range(3) == 0) add_reads();
            end
            for (int k = 0; k < 4; k++)
                pending_items.push_back(make_item(2'($urandom_range(3)),
                                                  12'($urandom_range(4095)),
                                                  8'($urandom_range(255))));
            wait_drained();
        end
        quiet_mode = 1'b0;
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
